// ===== hw/rtl/sitd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the signed integer to decimal text block
// no dependencies

package sitd_pkg;

  localparam int VALUE_BITS = 64;
  localparam int IN_BITS    = 64;
  // decimal digits needed for an unsigned value of VALUE_BITS bits
  localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [3:0] DIGIT_FIVE  = 4'd5;
  localparam logic [3:0] DIGIT_THREE = 4'd3;

  // per-cycle command to every digit cell of the row
  typedef struct packed {
    logic clr;
    logic dabble;
    logic dshift;
  } sitd_cell_ctrl_t;

endpackage

// ===== hw/rtl/signed_integer_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Converts one signed integer per request into its decimal ASCII text, most
// significant character first, a '-' ahead of negative values, no leading zeros,
// with last_char_o on the final character. One request is in flight at a time.
// The magnitude is shifted bit by bit through a row of bcd digit cells, then
// leading zero digits are dropped and the digits are shifted out of the top
// cell one a cycle while out_ready_i does not stall the output.
// Depends on sitd_pkg and sitd_cell.

module signed_integer_to_decimal_ascii
  import sitd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IN_BITS-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         char_code_o,
  output logic               last_char_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]  dig_cnt_q, dig_cnt_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] raw;
  logic                  accept;
  logic                  slot_free;
  logic [3:0]            top_digit;
  sitd_cell_ctrl_t       ctrl;

  logic [3:0] digit_w [DIGITS];
  logic       carry_w [DIGITS];

  assign raw        = value_i[VALUE_BITS-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign top_digit  = digit_w[DIGITS-1];

  // row of digit cells, cell 0 least significant
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_low
      assign bit_in   = mag_q[VALUE_BITS-1];
      assign digit_in = 4'd0;
    end else begin : g_up
      assign bit_in   = carry_w[i-1];
      assign digit_in = digit_w[i-1];
    end
    sitd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .digit_o (digit_w[i]),
      .carry_o (carry_w[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl        = '0;

    // minus sign goes out as soon as the output register is free
    if (neg_q && slot_free) begin
      out_valid_d = 1'b1;
      char_d      = CHAR_MINUS;
      last_d      = 1'b0;
      neg_d       = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_d     = raw[VALUE_BITS-1];
          mag_d     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
          bit_cnt_d = '0;
          ctrl.clr  = 1'b1;
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[VALUE_BITS-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          dig_cnt_d = DIG_CNT_W'(DIGITS);
          state_d   = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_digit == 4'd0 && dig_cnt_q > DIG_CNT_W'(1)) begin
          ctrl.dshift = 1'b1;
          dig_cnt_d   = dig_cnt_q - 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!neg_q && slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + {4'd0, top_digit};
          last_d      = (dig_cnt_q == DIG_CNT_W'(1));
          ctrl.dshift = 1'b1;
          dig_cnt_d   = dig_cnt_q - 1'b1;
          if (dig_cnt_q == DIG_CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

// ===== hw/rtl/sitd_cell.sv =====
`timescale 1ns / 1ps
// one bcd digit cell: clear, add-3 and shift step, or whole-digit shift upwards
// depends on sitd_pkg

module sitd_cell
  import sitd_pkg::*;
(
  input  logic            clk_i,
  input  sitd_cell_ctrl_t ctrl_i,
  input  logic            bit_i,
  input  logic [3:0]      digit_i,
  output logic [3:0]      digit_o,
  output logic            carry_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  assign adj     = (digit_q >= DIGIT_FIVE) ? digit_q + DIGIT_THREE : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== hw/rtl/sitd_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for signed_integer_to_decimal_ascii, bound to the top level
// depends on sitd_pkg

module sitd_checker
  import sitd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [IN_BITS-1:0] value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         char_code_o,
  input logic               last_char_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o && (value_i == value_i);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o)
      && $stable(last_char_o))
    else $error("stalled output changed");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_code_o == CHAR_MINUS
      || (char_code_o >= CHAR_ZERO && char_code_o <= CHAR_ZERO + 8'd9))
    else $error("output is not a minus sign or a digit");

  // a minus sign is never marked as the last character
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o == CHAR_MINUS |-> !last_char_o)
    else $error("minus sign marked as last character");

  // one request at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("new request taken while converting");

endmodule

bind signed_integer_to_decimal_ascii sitd_checker u_sitd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_code_o (char_code_o),
  .last_char_o (last_char_o)
);
